// ===== rtl/ule_pkg.sv =====
// Package: shared constants, types and helper functions for the UTF-8 line edit buffer.
package ule_pkg;

   localparam int BUFFER_BYTES = 256;
   localparam int ADDR_W = $clog2(BUFFER_BYTES);
   localparam int LEN_W = ADDR_W + 1;

   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_BOUNDARY = 2'd1;
   localparam logic [1:0] ST_EXIT     = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [20:0] KEY_BS    = 21'd8;
   localparam logic [20:0] KEY_LF    = 21'd10;
   localparam logic [20:0] KEY_CR    = 21'd13;
   localparam logic [20:0] KEY_ESC   = 21'd27;
   localparam logic [20:0] KEY_LEFT  = 21'd28;
   localparam logic [20:0] KEY_RIGHT = 21'd29;
   localparam logic [20:0] KEY_DEL   = 21'd127;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BACK_RD,    // issue read of byte before scan position
      S_BACK_CHK,   // examine it
      S_FWD_RD,     // issue read of lead byte at cursor
      S_FWD_CHK,
      S_SHIFT_RD,   // copy loop: read
      S_SHIFT_WR,   // copy loop: write
      S_FILL,       // write encoded bytes
      S_READ_RD,
      S_READ_WAIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [LEN_W-1:0] length;
      logic [LEN_W-1:0] cursor;
      logic [7:0]  read_byte;
   } rsp_type;

   // number of leading ones of a lead byte, 1 for ASCII or bare continuation
   function automatic logic [3:0] lead_count(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c < 8'h80) begin
         n = 4'd1;
      end else begin
         for (int i = 7; i >= 0; i--) begin
            if (c[i] && n == 4'(7 - i)) n = n + 4'd1;
         end
      end
      return n;
   endfunction

   // numeric-expression mapping of one typed code
   function automatic logic [7:0] numeric_byte(input logic [20:0] ch);
      logic [7:0] r;
      logic [20:0] v;
      logic [3:0] m;
      logic [41:0] prod;
      logic [20:0] q;
      r = 8'h30;
      if (ch >= 21'h30 && ch <= 21'h39) r = ch[7:0];
      else if (ch == 21'h2B || ch == 21'h2A || ch == 21'h2F || ch == 21'h5E) r = ch[7:0];
      else if (ch == 21'h2D || ch == 21'h3D) r = 8'h2D;
      else if (ch >= 21'h20 && ch <= 21'h3F) r = 8'h2E;
      else if (ch == 21'h45 || ch == 21'h5F) r = 8'h65;
      else if (ch < 21'd7) begin
         // negative remainder: 7-ch in 1..7, byte is '0' - that
         r = 8'h30 - 8'(21'd7 - ch);
      end else begin
         // remainder by ten via reciprocal multiply, exact for v below 2^22
         v = ch - 21'd7;
         prod = 42'(v) * 42'd1677722;
         q = 21'(prod[41:24]);
         m = 4'(v - q * 21'd10);
         r = 8'h30 + {4'd0, m};
      end
      return r;
   endfunction

endpackage

// ===== rtl/ule_if.sv =====
// Interfaces: request, response and register-write channels.
interface ule_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [20:0] code;
   logic [7:0]  index;
   modport source (output valid, kind, code, index, input ready);
   modport sink   (input valid, kind, code, index, output ready);
endinterface

interface ule_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [8:0] length;
   logic [8:0] cursor;
   logic [7:0] read_byte;
   modport source (output valid, status, length, cursor, read_byte, input ready);
   modport sink   (input valid, status, length, cursor, read_byte, output ready);
endinterface

interface ule_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/ule_ram.sv =====
// Generic single-port RAM with registered read.
module ule_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ===== rtl/ule_encoder.sv =====
// UTF-8 / numeric encoder: turns a typed code into up to four bytes.
module ule_encoder
   import ule_pkg::*;
(
   input  logic [20:0] code,
   input  logic        numeric_mode,
   output logic [31:0] bytes,   // byte 0 in [7:0]
   output logic [2:0]  count
);
   always_comb begin
      bytes = '0;
      count = 3'd1;
      if (numeric_mode) begin
         bytes[7:0] = numeric_byte(code);
      end else if (code < 21'h80) begin
         bytes[7:0] = code[7:0];
      end else if (code < 21'h800) begin
         bytes[7:0]  = {3'b110, code[10:6]};
         bytes[15:8] = {2'b10, code[5:0]};
         count = 3'd2;
      end else if (code < 21'h10000) begin
         bytes[7:0]   = {4'b1110, code[15:12]};
         bytes[15:8]  = {2'b10, code[11:6]};
         bytes[23:16] = {2'b10, code[5:0]};
         count = 3'd3;
      end else if (code < 21'h110000) begin
         bytes[7:0]   = {5'b11110, code[20:18]};
         bytes[15:8]  = {2'b10, code[17:12]};
         bytes[23:16] = {2'b10, code[11:6]};
         bytes[31:24] = {2'b10, code[5:0]};
         count = 3'd4;
      end else begin
         bytes[7:0] = 8'h3F;
      end
   end
endmodule

// ===== rtl/utf8_line_edit_buffer.sv =====
// Top level: UTF-8 line edit buffer with a byte store and a byte-at-a-time move sequencer.
// Exits, clears and boundary cases go straight to the response; rejects pass a sizing step and
// reads a RAM read and wait state first. Inserts and deletes move the bytes behind the cursor
// one at a time, read then write, through the single RAM port, plus scans of up to 4 bytes.
// One item at a time; req ready only in idle with no response waiting. Reset (synchronous)
// empties the text and clears numeric mode; the store itself is not cleared.
module utf8_line_edit_buffer
   import ule_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ule_req_if.sink   req,
   ule_rsp_if.source rsp,
   ule_csr_if.sink   csr
);
   state_type state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in, cur_ff, cur_in;
   logic [LEN_W-1:0] pos_ff, pos_in;       // scan / copy position
   logic [LEN_W-1:0] end_ff, end_in;       // copy end / target
   logic [2:0]       n_ff, n_in;           // span size
   logic [2:0]       k_ff, k_in;           // fill counter
   logic             up_ff, up_in;         // copy direction: 1 = insert (move up)
   logic             mv_ff, mv_in;         // cursor move only (left or right), no delete
   logic [20:0] code_ff, code_in;
   logic [7:0]  idx_ff, idx_in;
   logic        num_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rv_ff, rv_in;

   logic             we;
   logic [ADDR_W-1:0] addr;
   logic [7:0]       wdata, rdata;
   logic [31:0]      enc;
   logic [2:0]       enc_n;
   logic [3:0]       lc;
   logic [LEN_W-1:0] rem;

   ule_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   ule_encoder u_enc (.code(code_ff), .numeric_mode(num_ff), .bytes(enc), .count(enc_n));

   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rv_ff;
   assign rsp.status = rsp_ff.status;
   assign rsp.length = rsp_ff.length;
   assign rsp.cursor = rsp_ff.cursor;
   assign rsp.read_byte = rsp_ff.read_byte;

   assign lc  = lead_count(rdata);
   assign rem = len_ff - cur_ff;

   // register write
   always_ff @(posedge clock) begin
      if (reset) num_ff <= 1'b0;
      else if (csr.valid) num_ff <= csr.data;
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff <= '0;
         cur_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         cur_ff <= cur_in;
         rv_ff <= rv_in;
      end
      pos_ff <= pos_in; end_ff <= end_in; n_ff <= n_in; k_ff <= k_in;
      up_ff <= up_in; mv_ff <= mv_in; code_ff <= code_in;
      idx_ff <= idx_in; rsp_ff <= rsp_in;
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      len_in = len_ff; cur_in = cur_ff;
      pos_in = pos_ff; end_in = end_ff; n_in = n_ff; k_in = k_ff;
      up_in = up_ff; mv_in = mv_ff;
      code_in = code_ff; idx_in = idx_ff;
      rsp_in = rsp_ff; rv_in = rv_ff;
      we = 1'b0;
      addr = pos_ff[ADDR_W-1:0];
      wdata = 8'd0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               code_in = req.code; idx_in = req.index;
               state_in = S_RESP;
               rsp_in.status = ST_DONE;
               rsp_in.read_byte = 8'd0;
               if (req.kind == KIND_READ) begin
                  state_in = S_READ_RD;
               end else if (req.kind == KIND_CLEAR) begin
                  len_in = '0; cur_in = '0;
               end else if (req.kind == KIND_KEY) begin
                  pos_in = cur_ff;
                  if (req.code == KEY_BS || req.code == KEY_LEFT) begin
                     mv_in = (req.code == KEY_LEFT);
                     if (cur_ff == '0) rsp_in.status = ST_BOUNDARY;
                     else state_in = S_BACK_RD;
                  end else if (req.code == KEY_DEL || req.code == KEY_RIGHT) begin
                     mv_in = (req.code == KEY_RIGHT);
                     if (cur_ff >= len_ff) rsp_in.status = ST_BOUNDARY;
                     else state_in = S_FWD_RD;
                  end else if (req.code == KEY_LF || req.code == KEY_CR
                               || req.code == KEY_ESC) begin
                     rsp_in.status = ST_EXIT;
                  end else begin
                     state_in = S_FILL; // settles size next cycle
                     k_in = 3'd0;
                     up_in = 1'b1;
                  end
               end
            end
         end
         S_BACK_RD: begin
            addr = ADDR_W'(pos_ff - 1'b1);
            state_in = S_BACK_CHK;
         end
         S_BACK_CHK: begin
            // pos-1 byte in rdata
            pos_in = pos_ff - 1'b1;
            if (rdata[7:6] == 2'b10 && pos_ff > LEN_W'(1)) state_in = S_BACK_RD;
            else begin
               // character start at pos-1
               if (mv_ff) begin
                  cur_in = pos_ff - 1'b1;
                  state_in = S_RESP;
               end else begin
                  // delete [pos-1, cur): move bytes down
                  n_in = 3'(cur_ff - (pos_ff - 1'b1));
                  up_in = 1'b0;
                  end_in = len_ff - LEN_W'(cur_ff - (pos_ff - 1'b1));
                  len_in = len_ff - LEN_W'(cur_ff - (pos_ff - 1'b1));
                  cur_in = pos_ff - 1'b1;
                  state_in = (pos_ff - 1'b1 < len_ff - LEN_W'(cur_ff - (pos_ff - 1'b1)))
                             ? S_SHIFT_RD : S_RESP;
               end
            end
         end
         S_FWD_RD: begin
            state_in = S_FWD_CHK;
         end
         S_FWD_CHK: begin
            n_in = ({5'd0, lc} > rem) ? 3'(rem) : 3'(lc);
            if (mv_ff) begin
               cur_in = cur_ff + (({5'd0, lc} > rem) ? rem : LEN_W'(lc));
               state_in = S_RESP;
            end else begin
               up_in = 1'b0;
               pos_in = cur_ff;
               end_in = len_ff - (({5'd0, lc} > rem) ? rem : LEN_W'(lc));
               len_in = len_ff - (({5'd0, lc} > rem) ? rem : LEN_W'(lc));
               state_in = (cur_ff < len_ff - (({5'd0, lc} > rem) ? rem : LEN_W'(lc)))
                          ? S_SHIFT_RD : S_RESP;
            end
         end
         S_SHIFT_RD: begin
            // down: read pos+n, write pos ; up: read pos-1, write pos-1+n
            addr = up_ff ? ADDR_W'(pos_ff - 1'b1) : ADDR_W'(pos_ff + LEN_W'(n_ff));
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            we = 1'b1;
            wdata = rdata;
            if (up_ff) begin
               addr = ADDR_W'(pos_ff - 1'b1 + LEN_W'(n_ff));
               pos_in = pos_ff - 1'b1;
               state_in = (pos_ff - 1'b1 > cur_ff) ? S_SHIFT_RD : S_FILL;
            end else begin
               addr = pos_ff[ADDR_W-1:0];
               pos_in = pos_ff + 1'b1;
               state_in = (pos_ff + 1'b1 < end_ff) ? S_SHIFT_RD : S_RESP;
            end
         end
         S_FILL: begin
            if (!up_ff) begin
               // entry from idle sets the up flag; without it, respond
               state_in = S_RESP;
            end else if (k_ff == 3'd0 && mv_ff == 1'b0 && pos_ff == cur_ff
                         && end_ff != len_ff + LEN_W'(enc_n)) begin
               // sizing step on entry
               n_in = enc_n;
               if ({1'b0, len_ff} + (LEN_W+1)'(enc_n) > (LEN_W+1)'(BUFFER_BYTES)) begin
                  rsp_in.status = ST_FULL;
                  state_in = S_RESP;
               end else begin
                  end_in = len_ff + LEN_W'(enc_n);
                  pos_in = len_ff;
                  state_in = (len_ff > cur_ff) ? S_SHIFT_RD : S_FILL;
               end
            end else begin
               we = 1'b1;
               addr = ADDR_W'(cur_ff + LEN_W'(k_ff));
               wdata = enc[8*k_ff +: 8];
               k_in = k_ff + 3'd1;
               if (k_ff + 3'd1 == n_ff) begin
                  len_in = end_ff;
                  cur_in = cur_ff + LEN_W'(n_ff);
                  state_in = S_RESP;
               end
            end
         end
         S_READ_RD: begin
            addr = idx_ff[ADDR_W-1:0];
            state_in = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            if ({1'b0, idx_ff} < len_ff) rsp_in.read_byte = rdata;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rv_ff) begin
               rsp_in.length = len_ff;
               rsp_in.cursor = cur_ff;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // insert entry: mark end_ff impossible so the sizing step runs once
      if (state_ff == S_IDLE && req.valid && req.ready && state_in == S_FILL) begin
         end_in = '1;
         mv_in = 1'b0;
         pos_in = cur_ff;
      end
   end
endmodule

// ===== rtl/ule_checker.sv =====
// Checker: port-level properties of the line edit buffer, bound to the top level.
module ule_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [8:0] rsp_length,
   input logic [8:0] rsp_cursor
);
   a_cur_le_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor <= rsp_length)
      else $error("cursor beyond length");

   a_len_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length <= 9'd256)
      else $error("length beyond buffer");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted while busy");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         rsp_valid && $stable({rsp_status, rsp_length, rsp_cursor}))
      else $error("response dropped");
endmodule

bind utf8_line_edit_buffer ule_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_length(rsp.length), .rsp_cursor(rsp.cursor)
);

// ===== bench/tb_top.sv =====
// Testbench for the UTF-8 line edit buffer: directed and random editing checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import ule_pkg::*;

   localparam int IDLE_LIMIT = 6000;

   logic clock;
   logic reset;

   ule_req_if req ();
   ule_rsp_if rsp ();
   ule_csr_if csr ();

   utf8_line_edit_buffer uut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // predictor state
   logic [7:0]  text_shadow [BUFFER_BYTES];
   int unsigned text_len;
   int unsigned cursor_at;
   bit          numeric_on;

   rsp_type     pending_rsp [$];
   int          fail_count;
   int          burst_left;
   int          idle_cycles;
   logic [15:0] stall_pat;
   int          stall_age;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // start of the character before position p
   function automatic int unsigned char_start(int unsigned p);
      while (p > 0 && text_shadow[p-1][7:6] == 2'b10) p--;
      if (p > 0) p--;
      return p;
   endfunction

   // byte count of the character at position p, clamped to the text
   function automatic int unsigned char_span(int unsigned p);
      int unsigned n;
      logic [7:0] c;
      c = text_shadow[p];
      n = 0;
      if (c < 8'h80) n = 1;
      else while (c[7]) begin
         n++;
         c = c << 1;
      end
      if (n > text_len - p) n = text_len - p;
      return n;
   endfunction

   function automatic void drop_bytes(int unsigned p, int unsigned n);
      for (int unsigned i = p; i + n < text_len; i++) text_shadow[i] = text_shadow[i+n];
      text_len -= n;
   endfunction

   function automatic logic [7:0] numeric_char(logic [20:0] ch);
      int v;
      if (ch >= 21'h30 && ch <= 21'h39) return ch[7:0];
      if (ch == 21'h2B || ch == 21'h2A || ch == 21'h2F || ch == 21'h5E) return ch[7:0];
      if (ch == 21'h2D || ch == 21'h3D) return 8'h2D;
      if (ch >= 21'h20 && ch <= 21'h3F) return 8'h2E;
      if (ch == 21'h45 || ch == 21'h5F) return 8'h65;
      v = int'(ch) - 7;
      return 8'(48 + v % 10);
   endfunction

   // encode and insert one typed code at the cursor
   function automatic logic [1:0] insert_code(logic [20:0] ch);
      logic [7:0] b [4];
      int unsigned n;
      if (numeric_on) begin
         b[0] = numeric_char(ch); n = 1;
      end else if (ch < 21'h80) begin
         b[0] = ch[7:0]; n = 1;
      end else if (ch < 21'h800) begin
         b[0] = 8'hC0 | 8'(ch >> 6); b[1] = 8'h80 | 8'(ch[5:0]); n = 2;
      end else if (ch < 21'h10000) begin
         b[0] = 8'hE0 | 8'(ch >> 12); b[1] = 8'h80 | 8'(ch[11:6]);
         b[2] = 8'h80 | 8'(ch[5:0]); n = 3;
      end else if (ch < 21'h110000) begin
         b[0] = 8'hF0 | 8'(ch >> 18); b[1] = 8'h80 | 8'(ch[17:12]);
         b[2] = 8'h80 | 8'(ch[11:6]); b[3] = 8'h80 | 8'(ch[5:0]); n = 4;
      end else begin
         b[0] = 8'h3F; n = 1;
      end
      if (text_len + n > BUFFER_BYTES) return ST_FULL;
      for (int i = int'(text_len) - 1; i >= int'(cursor_at); i--) text_shadow[i+n] = text_shadow[i];
      for (int unsigned i = 0; i < n; i++) text_shadow[cursor_at+i] = b[i];
      text_len += n;
      cursor_at += n;
      return ST_DONE;
   endfunction

   function automatic logic [1:0] apply_key(logic [20:0] ch);
      int unsigned k;
      case (ch)
         KEY_BS: begin
            if (cursor_at == 0) return ST_BOUNDARY;
            k = char_start(cursor_at);
            drop_bytes(k, cursor_at - k);
            cursor_at = k;
         end
         KEY_DEL: begin
            if (cursor_at >= text_len) return ST_BOUNDARY;
            drop_bytes(cursor_at, char_span(cursor_at));
         end
         KEY_LF, KEY_CR, KEY_ESC: return ST_EXIT;
         KEY_LEFT: begin
            if (cursor_at == 0) return ST_BOUNDARY;
            cursor_at = char_start(cursor_at);
         end
         KEY_RIGHT: begin
            if (cursor_at >= text_len) return ST_BOUNDARY;
            cursor_at += char_span(cursor_at);
         end
         default: return insert_code(ch);
      endcase
      return ST_DONE;
   endfunction

   function automatic rsp_type edit_result(logic [1:0] kind, logic [20:0] ch,
                                           logic [7:0] idx);
      rsp_type r;
      r = '0;
      if (kind == KIND_KEY) r.status = apply_key(ch);
      else if (kind == KIND_READ) begin
         if (idx < text_len) r.read_byte = text_shadow[idx];
      end else if (kind == KIND_CLEAR) begin
         text_len = 0;
         cursor_at = 0;
      end
      r.length = LEN_W'(text_len);
      r.cursor = LEN_W'(cursor_at);
      return r;
   endfunction

   // send one item in bursts with random gaps, predicting on acceptance
   task automatic send_item(logic [1:0] kind, logic [20:0] ch, logic [7:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
      end
      burst_left--;
      req.valid <= 1'b1;
      req.kind  <= kind;
      req.code  <= ch;
      req.index <= idx;
      do @(posedge clock); while (!req.ready);
      pending_rsp.push_back(edit_result(kind, ch, idx));
   endtask

   task automatic send_key(logic [20:0] ch);
      send_item(KIND_KEY, ch, 8'($urandom));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      burst_left = 0;
      wait (pending_rsp.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(bit m);
      drain();
      csr.valid <= 1'b1;
      csr.data  <= m;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      numeric_on = m;
   endtask

   // boundaries on an empty buffer, exit codes, unused kind, a read, clear
   task automatic test_boundaries();
      send_key(KEY_BS);
      send_key(KEY_DEL);
      send_key(KEY_LEFT);
      send_key(KEY_RIGHT);
      send_key(KEY_LF);
      send_key(KEY_CR);
      send_key(KEY_ESC);
      send_item(2'd3, 21'h1FFFFF, 8'hFF);
      send_item(KIND_READ, 21'd0, 8'd0);
      send_item(KIND_CLEAR, 21'h1FFFFF, 8'hFF);
   endtask

   // every encoding length, out-of-range codes, reads, moves and deletes across them
   task automatic test_encodings();
      send_key(21'd0);
      send_key(21'h7F - 21'd1);
      send_key(21'h80);
      send_key(21'h7FF);
      send_key(21'h800);
      send_key(21'hD800);
      send_key(21'hFFFF);
      send_key(21'h10000);
      send_key(21'h10FFFF);
      send_key(21'h110000);
      send_key(21'h1FFFFF);
      for (int i = 0; i < 20; i += 3) send_item(KIND_READ, 21'd0, 8'(i));
      send_item(KIND_READ, 21'd0, 8'hFF);
      repeat (4) send_key(KEY_LEFT);
      send_key(KEY_DEL);
      send_key(KEY_RIGHT);
      send_key(KEY_BS);
      send_key(KEY_RIGHT);
      send_key(KEY_RIGHT);
      send_key(KEY_RIGHT);
      send_key(KEY_DEL);
   endtask

   // fill to exactly the capacity and check rejection
   task automatic test_full_buffer();
      send_item(KIND_CLEAR, 21'd0, 8'd0);
      repeat (BUFFER_BYTES / 4 - 1) send_key(21'($urandom_range(21'h10000, 21'h10FFFF)));
      send_key(21'h800);
      send_key(21'h41);
      send_key(21'h41);
      send_key(21'h42);
      send_key(21'h10000);
      send_item(KIND_READ, 21'd0, 8'hFF);
      repeat (3) send_key(KEY_LEFT);
      send_key(KEY_BS);
      send_key(21'h10FFFF);
      send_key(21'h7FF);
      send_key(KEY_DEL);
      send_item(KIND_CLEAR, 21'd0, 8'd0);
   endtask

   // numeric mapping of each character class
   task automatic test_numeric_map();
      logic [20:0] codes [] = '{21'd0, 21'd6, 21'd7, 21'h30, 21'h39, 21'h2B, 21'h2A, 21'h2F,
                                21'h5E, 21'h2D, 21'h3D, 21'h20, 21'h3F, 21'h45, 21'h5F,
                                21'h1FFFFF, 21'h41};
      foreach (codes[i]) send_key(codes[i]);
      send_item(KIND_READ, 21'd0, 8'd1);
   endtask

   function automatic logic [20:0] random_code();
      case ($urandom_range(0, 5))
         0: return 21'($urandom_range(32, 126));
         1: return 21'($urandom_range(21'h80, 21'h7FF));
         2: return 21'($urandom_range(21'h800, 21'hFFFF));
         3: return 21'($urandom_range(21'h10000, 21'h10FFFF));
         4: return 21'($urandom_range(21'h110000, 21'h1FFFFF));
         default: return 21'($urandom);
      endcase
   endfunction

   // mostly editing keys and inserts, some reads, rare clears and noise
   task automatic test_random_editing(int count);
      int r;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (text_len > 240 && $urandom_range(0, 3) == 0)
            send_item(KIND_CLEAR, 21'($urandom), 8'($urandom));
         else if (r < 10) send_key(KEY_BS);
         else if (r < 18) send_key(KEY_DEL);
         else if (r < 28) send_key(KEY_LEFT);
         else if (r < 38) send_key(KEY_RIGHT);
         else if (r < 41) begin
            case ($urandom_range(0, 2))
               0: send_key(KEY_LF);
               1: send_key(KEY_CR);
               default: send_key(KEY_ESC);
            endcase
         end else if (r < 50)
            send_item(KIND_READ, 21'($urandom),
                      $urandom_range(0, 1) ? 8'($urandom) :
                      8'($urandom_range(0, text_len > 0 ? text_len - 1 : 0)));
         else if (r < 51) send_item(KIND_CLEAR, 21'($urandom), 8'($urandom));
         else if (r < 52) send_item(2'd3, 21'($urandom), 8'($urandom));
         else send_key(random_code());
      end
   endtask

   // receiver stall pattern, changed now and then, sometimes none at all
   always @(posedge clock) begin
      if (reset) begin
         stall_pat <= '0;
         stall_age <= 0;
         rsp.ready <= 1'b0;
      end else begin
         stall_age <= stall_age + 1;
         if (stall_age % 97 == 0)
            stall_pat <= ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom);
         else
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
         rsp.ready <= ~stall_pat[0];
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rsp.size() == 0) begin
            $error("response with none expected");
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp.status);
               fail_count++;
            end
            if (rsp.length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp.length);
               fail_count++;
            end
            if (rsp.cursor !== want.cursor) begin
               $error("cursor: expected %0d, got %0d", want.cursor, rsp.cursor);
               fail_count++;
            end
            if (rsp.read_byte !== want.read_byte) begin
               $error("read_byte: expected %0h, got %0h", want.read_byte, rsp.read_byte);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req.valid = 1'b0;
      req.kind = '0;
      req.code = '0;
      req.index = '0;
      csr.valid = 1'b0;
      csr.data = 1'b0;
      text_len = 0;
      cursor_at = 0;
      numeric_on = 1'b0;
      fail_count = 0;
      burst_left = 0;
      idle_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_boundaries();
      test_encodings();
      test_full_buffer();
      write_mode(1'b1);
      test_numeric_map();
      test_random_editing(120);
      write_mode(1'b0);
      test_random_editing(244);
      write_mode(1'b1);
      test_random_editing(40);
      write_mode(1'b0);
      test_random_editing(30);
      drain();
      repeat (20) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ule_pkg.sv
rtl/ule_if.sv
rtl/ule_ram.sv
rtl/ule_encoder.sv
rtl/utf8_line_edit_buffer.sv
rtl/ule_checker.sv
bench/tb_top.sv
